// ===== rtl/core/acd_pkg.sv =====
// Shared types, constants and AES helper functions for the CBC decryptor.
package acd_pkg;

	// Round-key memory address and key-schedule word index widths (up to 16 rows).
	localparam int RA_W = 4;
	localparam int WI_W = RA_W + 2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_KEY_MODE = 3'd0;
	localparam logic [2:0] CFG_KEY_0    = 3'd1;
	localparam logic [2:0] CFG_KEY_1    = 3'd2;
	localparam logic [2:0] CFG_KEY_2    = 3'd3;
	localparam logic [2:0] CFG_KEY_3    = 3'd4;
	localparam logic [2:0] CFG_IV_HI    = 3'd5;
	localparam logic [2:0] CFG_IV_LO    = 3'd6;

	// Key size codes.
	localparam logic [1:0] KEY_128 = 2'd0;
	localparam logic [1:0] KEY_192 = 2'd1;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	localparam logic [7:0] RCON [10] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	// Command from controller to datapath.
	typedef struct packed {
		logic            exp_en;    // produce one key-schedule word
		logic [WI_W-1:0] widx;      // word index
		logic [2:0]      wmod;      // word index mod Nk
		logic [3:0]      ri;        // round constant index
		logic            rd_en;     // read one round-key row
		logic [RA_W-1:0] rd_addr;
		logic            add_key;   // initial AddRoundKey
		logic            round_en;  // one inverse round
		logic            round_last;
		logic            finish;    // load output item, advance chain
	} acd_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic [3:0]      nk;
		logic [RA_W-1:0] nr;
	} acd_stat_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_EXPAND = 6'b000010,
		ST_KEYRD  = 6'b000100,
		ST_ADDK   = 6'b001000,
		ST_ROUND  = 6'b010000,
		ST_FIN    = 6'b100000
	} acd_state_t;

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte k of a block sits at bits [127-8k -: 8].
	function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				t[127 - 8*(r + 4*c) -: 8] =
					INV_SBOX[s[127 - 8*(r + 4*((c + 4 - r) % 4)) -: 8]];
			end
		end
		inv_shift_sub = t;
	endfunction

	function automatic logic [127:0] inv_mix(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				a[r]  = s[127 - 8*(4*c + r) -: 8];
				x2[r] = xtime(a[r]);
				x4[r] = xtime(x2[r]);
				x8[r] = xtime(x4[r]);
				m9[r] = x8[r] ^ a[r];
				mb[r] = x8[r] ^ x2[r] ^ a[r];
				md[r] = x8[r] ^ x4[r] ^ a[r];
				me[r] = x8[r] ^ x4[r] ^ x2[r];
			end
			t[127 - 8*(4*c)     -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
			t[127 - 8*(4*c + 1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
			t[127 - 8*(4*c + 2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
			t[127 - 8*(4*c + 3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
		end
		inv_mix = t;
	endfunction

endpackage

// ===== rtl/core/acd_ram.sv =====
// Generic single-port-write RAM with registered read.
module acd_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 15,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/acd_ctrl.sv =====
// Sequencer for key expansion, inverse rounds and result hand-off.
module acd_ctrl import acd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  logic      cfg_we,
	input  acd_stat_t stat,
	output acd_cmd_t  cmd
);

	acd_state_t      state_q;
	logic            dirty_q;
	logic            out_valid_q;
	logic [WI_W-1:0] widx_q;
	logic [2:0]      wmod_q;
	logic [3:0]      ri_q;
	logic [RA_W-1:0] rnd_q;
	logic            accept;
	logic            exp_done;
	logic            slot_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign exp_done  = (widx_q == {stat.nr, 2'b11});
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.widx       = widx_q;
		cmd.wmod       = wmod_q;
		cmd.ri         = ri_q;
		cmd.exp_en     = (state_q == ST_EXPAND);
		case (state_q)
			ST_KEYRD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = stat.nr;
			end
			ST_ADDK: begin
				cmd.add_key = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = rnd_q - 1'b1;
			end
			ST_ROUND: begin
				cmd.round_en   = 1'b1;
				cmd.round_last = (rnd_q == '0);
				cmd.rd_en      = (rnd_q != '0);
				cmd.rd_addr    = rnd_q - 1'b1;
			end
			ST_FIN: begin
				cmd.finish = slot_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dirty_q     <= 1'b1;
			out_valid_q <= 1'b0;
			widx_q      <= '0;
			wmod_q      <= '0;
			ri_q        <= '0;
			rnd_q       <= '0;
		end else begin
			if (cfg_we) begin
				dirty_q <= 1'b1;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					widx_q <= '0;
					wmod_q <= '0;
					ri_q   <= '0;
					if (accept) begin
						state_q <= dirty_q ? ST_EXPAND : ST_KEYRD;
					end
				end
				ST_EXPAND: begin
					widx_q <= widx_q + 1'b1;
					wmod_q <= ({1'b0, wmod_q} == stat.nk - 4'd1) ? 3'd0 : wmod_q + 3'd1;
					if (wmod_q == 3'd0 && {{(WI_W-4){1'b0}}, stat.nk} <= widx_q) begin
						ri_q <= ri_q + 4'd1;
					end
					if (exp_done) begin
						dirty_q <= 1'b0;
						state_q <= ST_KEYRD;
					end
				end
				ST_KEYRD: begin
					rnd_q   <= stat.nr;
					state_q <= ST_ADDK;
				end
				ST_ADDK: begin
					rnd_q   <= rnd_q - 1'b1;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q - 1'b1;
					if (rnd_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/acd_datapath.sv =====
// Configuration registers, key expansion, inverse rounds, chaining and pad check.
module acd_datapath import acd_pkg::*; #(
	parameter int KEY_SCHEDULE_WORDS = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_load,
	input  logic [63:0] cipher_high,
	input  logic [63:0] cipher_low,
	input  logic        final_block,
	input  acd_cmd_t    cmd,
	output acd_stat_t   stat,
	output logic [63:0] plain_high,
	output logic [63:0] plain_low,
	output logic        final_out,
	output logic [4:0]  pad_length,
	output logic        pad_error
);

	localparam int ROWS   = KEY_SCHEDULE_WORDS / 4;
	localparam int MAX_NR = ROWS - 1;

	logic [1:0]   mode_q;
	logic [63:0]  key_q [4];
	logic [127:0] iv_q;
	logic [127:0] chain_q;
	logic         first_q;
	logic [127:0] cipher_q;
	logic         final_q;
	logic [127:0] st_q;
	logic [31:0]  win_q [8];

	logic [3:0]   nr_mode;
	logic [31:0]  key_word;
	logic [31:0]  w_back;
	logic [31:0]  t_word;
	logic [31:0]  new_word;
	logic         row_we;
	logic [127:0] rk;
	logic [127:0] x_round;
	logic [127:0] prev;
	logic [7:0]   last_byte;
	logic         pad_ok;
	logic         pad_big;

	always_comb begin
		case (mode_q)
			KEY_128: begin
				stat.nk = 4'd4;
				nr_mode = 4'd10;
			end
			KEY_192: begin
				stat.nk = 4'd6;
				nr_mode = 4'd12;
			end
			default: begin
				stat.nk = 4'd8;
				nr_mode = 4'd14;
			end
		endcase
		stat.nr = (nr_mode > 4'(MAX_NR)) ? RA_W'(MAX_NR) : RA_W'(nr_mode);
	end

	// Key schedule: one word per cycle, window holds the last eight words.
	always_comb begin
		key_word = cmd.widx[0] ? key_q[cmd.widx[2:1]][31:0] : key_q[cmd.widx[2:1]][63:32];
		case (stat.nk)
			4'd4:    w_back = win_q[3];
			4'd6:    w_back = win_q[5];
			default: w_back = win_q[7];
		endcase
		t_word = win_q[0];
		if (cmd.wmod == 3'd0) begin
			t_word = sub_word({win_q[0][23:0], win_q[0][31:24]});
			if (cmd.ri < 4'd10) begin
				t_word = t_word ^ {RCON[cmd.ri], 24'h0};
			end
		end else if (stat.nk == 4'd8 && cmd.wmod == 3'd4) begin
			t_word = sub_word(win_q[0]);
		end
		if (cmd.widx < {{(WI_W-4){1'b0}}, stat.nk}) begin
			new_word = key_word;
		end else begin
			new_word = w_back ^ t_word;
		end
		row_we = cmd.exp_en && (cmd.widx[1:0] == 2'b11);
	end

	acd_ram #(
		.WIDTH(128),
		.DEPTH(ROWS),
		.AW   (RA_W)
	) u_rk_ram (
		.clk  (clk),
		.we   (row_we),
		.waddr(cmd.widx[WI_W-1:2]),
		.wdata({win_q[2], win_q[1], win_q[0], new_word}),
		.re   (cmd.rd_en),
		.raddr(cmd.rd_addr),
		.rdata(rk)
	);

	assign x_round = inv_shift_sub(st_q) ^ rk;
	assign prev    = first_q ? iv_q : chain_q;

	// PKCS#7 check on the finished block.
	always_comb begin
		last_byte = st_q[7:0];
		pad_big   = (last_byte > 8'd16);
		pad_ok    = 1'b1;
		for (int j = 0; j < 16; j++) begin
			if (8'(j) < last_byte && st_q[8*j +: 8] != last_byte) begin
				pad_ok = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= KEY_128;
			key_q   <= '{default: '0};
			iv_q    <= '0;
			chain_q <= '0;
			first_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEY_MODE: mode_q      <= cfg_data[1:0];
					CFG_KEY_0:    key_q[0]    <= cfg_data;
					CFG_KEY_1:    key_q[1]    <= cfg_data;
					CFG_KEY_2:    key_q[2]    <= cfg_data;
					CFG_KEY_3:    key_q[3]    <= cfg_data;
					CFG_IV_HI:    iv_q[127:64] <= cfg_data;
					CFG_IV_LO:    iv_q[63:0]   <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.finish) begin
				chain_q <= cipher_q;
				first_q <= final_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_load) begin
			cipher_q <= {cipher_high, cipher_low};
			final_q  <= final_block;
		end
		if (cmd.exp_en) begin
			win_q[0] <= new_word;
			for (int k = 1; k < 8; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
		if (cmd.add_key) begin
			st_q <= cipher_q ^ rk;
		end else if (cmd.round_en) begin
			st_q <= cmd.round_last ? (x_round ^ prev) : inv_mix(x_round);
		end
		if (cmd.finish) begin
			plain_high <= st_q[127:64];
			plain_low  <= st_q[63:0];
			final_out  <= final_q;
			pad_length <= (final_q && !pad_big && pad_ok) ? last_byte[4:0] : 5'd0;
			pad_error  <= final_q && (pad_big || !pad_ok);
		end
	end

endmodule

// ===== rtl/core/aes_cbc_decryptor.sv =====
// AES-128/192/256 CBC decryptor top level with PKCS#7 check.
// After an item is accepted the controller reads the last round key, applies the initial
// AddRoundKey, runs Nr inverse rounds and loads the result once the output slot is free;
// the single shared inverse-round unit takes the next item only after that, when idle.
// After any configuration write the next item first expands the key schedule into the
// round-key RAM, one word per cycle.
// Reset (arst_n low) clears the configuration, chaining and control registers; the next block chains with the IV.
module aes_cbc_decryptor import acd_pkg::*; #(
	parameter int KEY_SCHEDULE_WORDS = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	// ciphertext item channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] cipher_high,
	input  logic [63:0] cipher_low,
	input  logic        final_block,
	// plaintext item channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] plain_high,
	output logic [63:0] plain_low,
	output logic        final_out,
	output logic [4:0]  pad_length,
	output logic        pad_error,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	acd_cmd_t  cmd;
	acd_stat_t stat;
	logic      cfg_we;
	logic      in_load;

	// Writes are always taken; software must only write while the block is idle, which the block itself does not enforce.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	// Capture the item on its accept edge; it is held until the result is loaded.
	assign in_load   = in_valid && !in_stall;

	acd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cfg_we   (cfg_we),
		.stat     (stat),
		.cmd      (cmd)
	);

	acd_datapath #(
		.KEY_SCHEDULE_WORDS(KEY_SCHEDULE_WORDS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_load    (in_load),
		.cipher_high(cipher_high),
		.cipher_low (cipher_low),
		.final_block(final_block),
		.cmd        (cmd),
		.stat       (stat),
		.plain_high (plain_high),
		.plain_low  (plain_low),
		.final_out  (final_out),
		.pad_length (pad_length),
		.pad_error  (pad_error)
	);

endmodule

// ===== rtl/core/acd_checker.sv =====
// Port-level checks on the decryptor result channel, bound to the top level.
module acd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] plain_high,
	input logic [63:0] plain_low,
	input logic        final_out,
	input logic [4:0]  pad_length,
	input logic        pad_error
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(plain_high) && $stable(plain_low)
			&& $stable(pad_length) && $stable(pad_error))
		else $error("stalled item changed");

	a_nonfinal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !final_out |-> pad_length == 5'd0 && !pad_error)
		else $error("pad info on non-final item");

	a_err_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pad_error |-> pad_length == 5'd0)
		else $error("pad length with pad error");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pad_length <= 5'd16)
		else $error("pad length over sixteen");

endmodule

bind aes_cbc_decryptor acd_checker u_acd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.plain_high(plain_high),
	.plain_low (plain_low),
	.final_out (final_out),
	.pad_length(pad_length),
	.pad_error (pad_error)
);
